>>> rtl/mmam_pkg.sv
// ----------------------------------------------------------------------------
// mmam_pkg
// Shared constants, codes, controller/datapath interface types and the
// saturating add for the mix-minus audio mixer.
// ----------------------------------------------------------------------------
package mmam_pkg;

  localparam int NUM_SOURCES   = 8;
  localparam int FRAME_SAMPLES = 512;
  localparam int MAX_OUT       = 8;
  localparam int SAMPLE_W      = 16;
  localparam int TIMEOUT_W     = 16;
  localparam int SLOT_W        = $clog2(NUM_SOURCES);
  localparam int POS_W         = $clog2(FRAME_SAMPLES);
  localparam int ADDR_W        = SLOT_W + POS_W;
  localparam int STORE_DEPTH   = NUM_SOURCES * FRAME_SAMPLES;
  localparam int CNT_W         = $clog2(MAX_OUT);

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
  localparam logic [TIMEOUT_W-1:0] AGE_MAX       = '1;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_MIX  = 2'd1,
    MODE_TICK = 2'd2
  } mode_e;

  typedef struct packed {
    logic load;       // write sample, maybe mark packet end
    logic tick;       // age active slots
    logic mix_start;  // latch position, noise, end of frame
    logic l_inc;      // next listener
    logic acc_init;   // accumulator <= noise, source counter <= 0
    logic issue_rd;   // read store for current source
    logic emit;       // present result word
    logic finish;     // mix done, drop fresh marks on end of frame
  } cmd_t;

  typedef struct packed {
    logic l_active;
    logic l_at_end;
    logic s_at_end;
    logic res_last;
  } sts_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_add(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] sum;
    sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sat_add = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat_add = sum[SAMPLE_W-1:0];
    end
  endfunction

endpackage

>>> rtl/mmam_ram.sv
// ----------------------------------------------------------------------------
// mmam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mmam_ctrl.sv
// ----------------------------------------------------------------------------
// mmam_ctrl
// Sequencer: accepts commands, walks listeners and sources for a mix word.
// ----------------------------------------------------------------------------
module mmam_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    mode_i,
  input  mmam_pkg::sts_t sts_i,
  output mmam_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import mmam_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_LOAD: cmd_o.load = 1'b1;
            MODE_TICK: cmd_o.tick = 1'b1;
            MODE_MIX: begin
              cmd_o.mix_start = 1'b1;
              state_d         = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.l_active) begin
          cmd_o.acc_init = 1'b1;
          state_d        = ST_READ;
        end else if (sts_i.l_at_end) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.l_inc = 1'b1;
        end
      end
      ST_READ: begin
        cmd_o.issue_rd = 1'b1;
        if (sts_i.s_at_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.res_last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.l_inc = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/mmam_dp.sv
// ----------------------------------------------------------------------------
// mmam_dp
// Datapath: sample store, slot marks and ages, saturating accumulator and
// result registers.
// ----------------------------------------------------------------------------
module mmam_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mmam_pkg::cmd_t       cmd_i,
  output mmam_pkg::sts_t       sts_o,
  input  logic [2:0]           source_index_i,
  input  logic [8:0]           sample_index_i,
  input  logic signed [15:0]   sample_value_i,
  input  logic signed [15:0]   noise_sample_i,
  input  logic                 end_of_packet_i,
  input  logic                 end_of_frame_i,
  input  logic                 timeout_we_i,
  input  logic [15:0]          timeout_wdata_i,
  output logic                 valid_o,
  output logic [2:0]           listener_index_o,
  output logic signed [15:0]   mixed_sample_o,
  output logic                 last_o
);
  import mmam_pkg::*;

  logic [NUM_SOURCES-1:0]   fresh_q;
  logic [NUM_SOURCES-1:0]   active_q;
  logic [TIMEOUT_W-1:0]     age_q [NUM_SOURCES];
  logic [TIMEOUT_W-1:0]     timeout_q;

  logic [POS_W-1:0]         pos_q;
  logic signed [SAMPLE_W-1:0] noise_q;
  logic                     eof_q;
  logic [SLOT_W-1:0]        l_q;
  logic [SLOT_W-1:0]        s_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     add_en_q;
  logic signed [SAMPLE_W-1:0] acc_q;

  logic                     out_valid_q;
  logic [2:0]               out_lst_q;
  logic signed [SAMPLE_W-1:0] out_mix_q;
  logic                     out_last_q;

  logic                     src_ok;
  logic [SLOT_W-1:0]        ld_slot;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        raddr;
  logic [SAMPLE_W-1:0]      rdata;
  logic                     above_any;

  assign src_ok  = ({1'b0, source_index_i} < 4'(NUM_SOURCES));
  assign ld_slot = SLOT_W'(source_index_i);
  assign waddr   = {ld_slot, POS_W'(sample_index_i)};
  assign raddr   = {s_q, pos_q};

  mmam_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && src_ok),
    .waddr_i (waddr),
    .wdata_i (sample_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    above_any = 1'b0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (active_q[i] && (SLOT_W'(i) > l_q)) begin
        above_any = 1'b1;
      end
    end
  end

  assign sts_o.l_active = active_q[l_q];
  assign sts_o.l_at_end = (l_q == SLOT_W'(NUM_SOURCES - 1));
  assign sts_o.s_at_end = (s_q == SLOT_W'(NUM_SOURCES - 1));
  assign sts_o.res_last = !above_any || (cnt_q == CNT_W'(MAX_OUT - 1));

  // slot marks, ages, timeout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q   <= '0;
      active_q  <= '0;
      timeout_q <= TIMEOUT_RESET;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      if (timeout_we_i) begin
        timeout_q <= timeout_wdata_i;
      end
      if (cmd_i.load && src_ok && end_of_packet_i) begin
        fresh_q[ld_slot]  <= 1'b1;
        active_q[ld_slot] <= 1'b1;
        age_q[ld_slot]    <= '0;
      end
      if (cmd_i.tick) begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          if (active_q[i]) begin
            if (age_q[i] != AGE_MAX) begin
              age_q[i] <= age_q[i] + 1'b1;
              if ((age_q[i] + 1'b1) > timeout_q) begin
                active_q[i] <= 1'b0;
              end
            end else if (age_q[i] > timeout_q) begin
              active_q[i] <= 1'b0;
            end
          end
        end
      end
      if (cmd_i.finish && eof_q) begin
        fresh_q <= '0;
      end
    end
  end

  // mix sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q         <= '0;
      s_q         <= '0;
      cnt_q       <= '0;
      eof_q       <= 1'b0;
      add_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      add_en_q    <= cmd_i.issue_rd && fresh_q[s_q] && (s_q != l_q);
      out_valid_q <= cmd_i.emit;
      if (cmd_i.mix_start) begin
        l_q   <= '0;
        cnt_q <= '0;
        eof_q <= end_of_frame_i;
      end
      if (cmd_i.l_inc) begin
        l_q <= l_q + 1'b1;
      end
      if (cmd_i.acc_init) begin
        s_q <= '0;
      end else if (cmd_i.issue_rd) begin
        s_q <= s_q + 1'b1;
      end
      if (cmd_i.emit) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.mix_start) begin
      pos_q   <= POS_W'(sample_index_i);
      noise_q <= noise_sample_i;
    end
    if (cmd_i.acc_init) begin
      acc_q <= noise_q;
    end else if (add_en_q) begin
      acc_q <= sat_add(acc_q, rdata);
    end
    if (cmd_i.emit) begin
      out_lst_q  <= 3'(l_q);
      out_mix_q  <= acc_q;
      out_last_q <= sts_o.res_last;
    end
  end

  assign valid_o          = out_valid_q;
  assign listener_index_o = out_lst_q;
  assign mixed_sample_o   = out_mix_q;
  assign last_o           = out_last_q;

endmodule

>>> rtl/mix_minus_audio_mixer.sv
// ----------------------------------------------------------------------------
// mix_minus_audio_mixer
// Conference mix-minus mixer: per-slot frame store, fresh/active tracking,
// saturating per-listener mix of all other fresh sources over a noise bed.
// ----------------------------------------------------------------------------
// Load and tick words do not raise busy. A mix word holds busy while it scans
// each slot up to the highest active one (all 8 if none is active) and, per
// active listener, runs scan, a store read for each of the 8 slots, drain
// and emit; the last result strobes as busy drops.
// Reset clears marks, ages and sequencer, timeout returns to 1000, the sample
// store keeps its contents. Results cannot be stalled by the receiver.
module mix_minus_audio_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         source_index_i,
  input  logic [8:0]         sample_index_i,
  input  logic signed [15:0] sample_value_i,
  input  logic signed [15:0] noise_sample_i,
  input  logic               end_of_packet_i,
  input  logic               end_of_frame_i,
  input  logic               timeout_we_i,
  input  logic [15:0]        timeout_wdata_i,
  output logic               valid_o,
  output logic [2:0]         listener_index_o,
  output logic signed [15:0] mixed_sample_o,
  output logic               last_o
);
  import mmam_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mmam_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  mmam_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .source_index_i   (source_index_i),
    .sample_index_i   (sample_index_i),
    .sample_value_i   (sample_value_i),
    .noise_sample_i   (noise_sample_i),
    .end_of_packet_i  (end_of_packet_i),
    .end_of_frame_i   (end_of_frame_i),
    .timeout_we_i     (timeout_we_i),
    .timeout_wdata_i  (timeout_wdata_i),
    .valid_o          (valid_o),
    .listener_index_o (listener_index_o),
    .mixed_sample_o   (mixed_sample_o),
    .last_o           (last_o)
  );

  a_mix_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (mode_i == MODE_MIX) |=> busy)
    else $error("mix word did not start the sequencer");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result word without a running mix");

  a_no_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result word right after the last one");

  a_load_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (mode_i != MODE_MIX) |=> !busy && !valid_o)
    else $error("load or tick word started a mix");

endmodule
